// File: design/fmc_pkg.sv
// Shared types, constants and AES-128 helper functions for the frame MIC CMAC block.
package fmc_pkg;

  localparam int MIC_BYTES_DEF = 4;
  localparam int MAX_MSG_DEF   = 255;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 64;

  localparam logic       CMD_START = 1'b0;
  localparam logic       CMD_DATA  = 1'b1;
  localparam logic [7:0] HDR_TAG   = 8'h49;
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [7:0] DBL_POLY  = 8'h87;
  localparam logic [7:0] RCON_INIT = 8'h01;

  localparam logic [1:0] REG_KEY_UPPER = 2'd0;
  localparam logic [1:0] REG_KEY_LOWER = 2'd1;
  localparam logic [1:0] REG_DEV_ADDR  = 2'd2;
  localparam logic [1:0] REG_DIRECTION = 2'd3;

  typedef enum logic [2:0] {
    JOB_START,
    JOB_START_EMPTY,
    JOB_CHAIN,
    JOB_LAST_K1,
    JOB_LAST_K2
  } job_kind_t;

  typedef struct packed {
    job_kind_t      kind;
    logic [127:0]   blk;
  } job_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // CMAC doubling in GF(2^128), byte 0 most significant
  function automatic logic [127:0] dbl(input logic [127:0] v);
    dbl = {v[126:0], 1'b0} ^ {120'd0, (v[127] ? DBL_POLY : 8'h00)};
  endfunction

  // next round key
  function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = rk[127:96] ^ 32'd0;
    w3 = rk[31:0];
    t  = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    w0 = rk[127:96] ^ t;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    key_step = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] st, input logic [127:0] rk,
                                             input logic last);
    logic [7:0] s [16];
    logic [7:0] o [16];
    logic [7:0] a0, a1, a2, a3, x;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) s[i] = SBOX[st[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int w = 0; w < 4; w++) o[w+4*c] = s[w + 4*((c+w) & 3)];
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = o[4*c]; a1 = o[4*c+1]; a2 = o[4*c+2]; a3 = o[4*c+3];
        x = a0 ^ a1 ^ a2 ^ a3;
        o[4*c]   = a0 ^ x ^ xt(a0 ^ a1);
        o[4*c+1] = a1 ^ x ^ xt(a1 ^ a2);
        o[4*c+2] = a2 ^ x ^ xt(a2 ^ a3);
        o[4*c+3] = a3 ^ x ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) r[127-8*i -: 8] = o[i];
    aes_round = r ^ rk;
  endfunction

endpackage

// File: design/fmc_front.sv
// Front end: takes start and data beats, builds header and message blocks, queues jobs.
module fmc_front #(
  parameter int MAX_MESSAGE_BYTES = fmc_pkg::MAX_MSG_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          in_cmd,
  input  logic [15:0]   in_frame_count,
  input  logic [7:0]    in_msg_length,
  input  logic [7:0]    in_data_byte,
  input  logic          direction,
  input  logic [31:0]   device_address,
  output logic          push,
  output fmc_pkg::job_t push_job
);

  logic         open_r;
  logic [3:0]   fill_r;
  logic [7:0]   left_r;
  logic [127:0] buf_r;
  logic [7:0]   len_sat;
  logic [127:0] hdr, blk_wr, blk_pad;

  always_comb begin
    len_sat = (int'(in_msg_length) > MAX_MESSAGE_BYTES) ? 8'(MAX_MESSAGE_BYTES) : in_msg_length;
    hdr = {fmc_pkg::HDR_TAG, 32'd0, 7'd0, direction,
           device_address[7:0], device_address[15:8], device_address[23:16],
           device_address[31:24], in_frame_count[7:0], in_frame_count[15:8], 24'd0, len_sat};
    blk_wr = buf_r;
    blk_wr[127 - 8*fill_r -: 8] = in_data_byte;
    for (int i = 0; i < 16; i++) begin
      if (i <= int'(fill_r))          blk_pad[127-8*i -: 8] = blk_wr[127-8*i -: 8];
      else if (i == int'(fill_r) + 1) blk_pad[127-8*i -: 8] = fmc_pkg::PAD_BYTE;
      else                            blk_pad[127-8*i -: 8] = 8'h00;
    end
    push = 1'b0;
    push_job.kind = fmc_pkg::JOB_CHAIN;
    push_job.blk  = blk_wr;
    if (in_fire) begin
      if (in_cmd == fmc_pkg::CMD_START) begin
        push = 1'b1;
        push_job.kind = (len_sat == 8'd0) ? fmc_pkg::JOB_START_EMPTY : fmc_pkg::JOB_START;
        push_job.blk  = hdr;
      end else if (open_r) begin
        if (left_r == 8'd1) begin
          push = 1'b1;
          push_job.kind = (fill_r == 4'd15) ? fmc_pkg::JOB_LAST_K1 : fmc_pkg::JOB_LAST_K2;
          push_job.blk  = blk_pad;
        end else if (fill_r == 4'd15) begin
          push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
      fill_r <= '0;
      left_r <= '0;
    end else if (in_fire) begin
      if (in_cmd == fmc_pkg::CMD_START) begin
        open_r <= (len_sat != 8'd0);
        fill_r <= '0;
        left_r <= len_sat;
      end else if (open_r) begin
        buf_r  <= blk_wr;
        left_r <= left_r - 8'd1;
        if (left_r == 8'd1) begin
          open_r <= 1'b0;
          fill_r <= '0;
        end else begin
          fill_r <= fill_r + 4'd1;
        end
      end
    end
  end

endmodule

// File: design/fmc_queue.sv
// Two-entry job queue between the front end and the cipher engine.
module fmc_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  fmc_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          pop_valid,
  output fmc_pkg::job_t pop_job
);

  fmc_pkg::job_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_job   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: design/fmc_back.sv
// Back end: round-per-cycle AES-128 engine with CMAC subkey, chaining and output register.
module fmc_back #(
  parameter int MIC_BYTES = fmc_pkg::MIC_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [127:0]  key,
  input  logic          job_valid,
  input  fmc_pkg::job_t job,
  output logic          job_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata
);

  typedef enum logic [1:0] {BK_IDLE, BK_RUN, BK_FIN} bk_state_t;

  bk_state_t          state_r;
  fmc_pkg::job_kind_t kind_r;
  logic               subkey_phase_r;
  logic [127:0]       hdr_r, st_r, rk_r, k1_r, k2_r, chain_r;
  logic [7:0]         rcon_r;
  logic [3:0]         rnd_r;
  logic               out_valid_r;
  logic [31:0]        out_mic_r;
  logic [127:0]       load_blk, k1_nxt, k2_nxt, rk_nxt;
  logic [31:0]        mic_nxt;
  logic               slot_free, emit, load_out;

  assign job_pop    = (state_r == BK_IDLE) && job_valid;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_mic_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    case (job.kind)
      fmc_pkg::JOB_CHAIN:   load_blk = job.blk ^ chain_r;
      fmc_pkg::JOB_LAST_K1: load_blk = job.blk ^ chain_r ^ k1_r;
      fmc_pkg::JOB_LAST_K2: load_blk = job.blk ^ chain_r ^ k2_r;
      default:              load_blk = '0;
    endcase
    k1_nxt = fmc_pkg::dbl(st_r);
    k2_nxt = fmc_pkg::dbl(k1_nxt);
    rk_nxt = fmc_pkg::key_step(rk_r, rcon_r);
    for (int i = 0; i < 4; i++)
      mic_nxt[8*i +: 8] = (i < MIC_BYTES) ? st_r[127-8*i -: 8] : 8'h00;
    emit = (kind_r == fmc_pkg::JOB_START_EMPTY) || (kind_r == fmc_pkg::JOB_LAST_K1) ||
           (kind_r == fmc_pkg::JOB_LAST_K2);
    // a new MIC enters the output register this cycle
    load_out = (state_r == BK_FIN) && !subkey_phase_r && emit && slot_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      k1_r        <= '0;
      k2_r        <= '0;
      chain_r     <= '0;
    end else begin
      if (out_valid_r && out_tready && !load_out) out_valid_r <= 1'b0;
      case (state_r)
        BK_IDLE: begin
          if (job_valid) begin
            kind_r         <= job.kind;
            hdr_r          <= job.blk;
            subkey_phase_r <= (job.kind == fmc_pkg::JOB_START) ||
                              (job.kind == fmc_pkg::JOB_START_EMPTY);
            st_r    <= load_blk ^ key;
            rk_r    <= key;
            rcon_r  <= fmc_pkg::RCON_INIT;
            rnd_r   <= 4'd1;
            state_r <= BK_RUN;
          end
        end
        BK_RUN: begin
          st_r   <= fmc_pkg::aes_round(st_r, rk_nxt, rnd_r == 4'd10);
          rk_r   <= rk_nxt;
          rcon_r <= fmc_pkg::xt(rcon_r);
          rnd_r  <= rnd_r + 4'd1;
          if (rnd_r == 4'd10) state_r <= BK_FIN;
        end
        BK_FIN: begin
          if (subkey_phase_r) begin
            // zero block done: derive subkeys, then cipher the header block
            k1_r           <= k1_nxt;
            k2_r           <= k2_nxt;
            chain_r        <= '0;
            subkey_phase_r <= 1'b0;
            st_r    <= hdr_r ^ ((kind_r == fmc_pkg::JOB_START_EMPTY) ? k1_nxt : '0) ^ key;
            rk_r    <= key;
            rcon_r  <= fmc_pkg::RCON_INIT;
            rnd_r   <= 4'd1;
            state_r <= BK_RUN;
          end else if (!emit) begin
            chain_r <= st_r;
            state_r <= BK_IDLE;
          end else if (slot_free) begin
            out_valid_r <= 1'b1;
            out_mic_r   <= mic_nxt;
            state_r     <= BK_IDLE;
          end
        end
        default: state_r <= BK_IDLE;
      endcase
    end
  end

endmodule

// File: design/frame_mic_cmac_top.sv
// Top level of the frame MIC AES-128 CMAC block: config registers, front, queue and engine.
// With an idle engine, a closing data beat gives a valid MIC beat after one AES pass; a
//   start beat with zero length after two passes (zero block for subkeys, then the header).
// Throughput: one data beat per cycle within a message while the queue has room; each 16-byte
//   block costs one AES pass (10 rounds, one per cycle, plus load and finish), a start two.
//   Short messages back to back fill the two-entry queue and stall in_tready.
// Reset: synchronous active-low rst_n clears config, queue, message state and output valid.
module frame_mic_cmac_top #(
  parameter int MIC_BYTES         = fmc_pkg::MIC_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = fmc_pkg::MAX_MSG_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: frame_count[15:0], msg_length[23:16], data_byte[31:24]
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [31:0]                in_tdata,
  // in_tuser: command[0] (0 start, 1 data byte)
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_tdata: mic[31:0], first cipher byte in bits 7:0
  output logic [31:0]                out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [fmc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [fmc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [fmc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [63:0]   key_upper_r, key_lower_r;
  logic [31:0]   dev_addr_r;
  logic          direction_r;
  logic          cfg_wr, in_fire, push, q_full, pop, pop_valid;
  logic [1:0]    reg_sel;
  fmc_pkg::job_t push_job, pop_job;

  // registers sit at 8-byte strides
  assign reg_sel    = cfg_paddr[4:3];
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_upper_r <= '0;
      key_lower_r <= '0;
      dev_addr_r  <= '0;
      direction_r <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        fmc_pkg::REG_KEY_UPPER: key_upper_r <= cfg_pwdata;
        fmc_pkg::REG_KEY_LOWER: key_lower_r <= cfg_pwdata;
        fmc_pkg::REG_DEV_ADDR:  dev_addr_r  <= cfg_pwdata[31:0];
        fmc_pkg::REG_DIRECTION: direction_r <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      fmc_pkg::REG_KEY_UPPER: cfg_prdata = key_upper_r;
      fmc_pkg::REG_KEY_LOWER: cfg_prdata = key_lower_r;
      fmc_pkg::REG_DEV_ADDR:  cfg_prdata = {32'd0, dev_addr_r};
      fmc_pkg::REG_DIRECTION: cfg_prdata = {63'd0, direction_r};
      default:                cfg_prdata = '0;
    endcase
  end

  // front keeps taking beats while the queue has room
  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  fmc_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_fire        (in_fire),
    .in_cmd         (in_tuser),
    .in_frame_count (in_tdata[15:0]),
    .in_msg_length  (in_tdata[23:16]),
    .in_data_byte   (in_tdata[31:24]),
    .direction      (direction_r),
    .device_address (dev_addr_r),
    .push           (push),
    .push_job       (push_job)
  );

  fmc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_job   (pop_job)
  );

  fmc_back #(.MIC_BYTES(MIC_BYTES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .key        ({key_upper_r, key_lower_r}),
    .job_valid  (pop_valid),
    .job        (pop_job),
    .job_pop    (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: design/fmc_checker.sv
// Port-level checker for the frame MIC CMAC top level, with its bind.
module fmc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("out beat dropped or changed under stall");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  a_pready: assert property (@(posedge clk)
    cfg_pready)
    else $error("cfg_pready low");

endmodule

bind frame_mic_cmac_top fmc_checker u_fmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);

// File: test/tb.sv
// Self-checking bench for frame_mic_cmac_top: MIC of AES-CMAC message streams.
module tb;

  localparam int STALL_LIMIT = 3000; // cycles with no beat on either side
  localparam int DRAIN_WAIT  = 100;  // covers start jobs queued behind a busy engine

  typedef struct {
    logic        cmd;
    logic [15:0] fcnt;
    logic [7:0]  mlen;
    logic [7:0]  dbyte;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [fmc_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [fmc_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  logic [fmc_pkg::CFG_DW-1:0] cfg_prdata;
  logic        cfg_pready;

  frame_mic_cmac_top DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of config and message state
  logic [127:0] key_m;
  logic [31:0]  dev_addr_m;
  logic         dir_m;
  logic [127:0] k1_m, k2_m, chain_m, blk_m;
  logic [7:0]   left_m;
  int           fill_m;
  logic         open_m;

  beat_t       pending_q[$];
  logic [31:0] mic_q[$];
  int          err_cnt = 0;
  int          idle_cnt = 0;
  logic        quiet = 1'b0;
  logic        in_acc = 1'b0;
  int          in_gap = 0;
  int          out_gap = 0;

  function automatic logic [7:0] gmul2(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // AES-128 encrypt, byte 0 in bits 127:120
  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk[176];
    logic [7:0] s[16];
    logic [7:0] o[16];
    logic [7:0] t[4];
    logic [7:0] f, rc, a0, a1, a2, a3, x;
    logic [127:0] ct;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) begin
      rk[i] = key[127-8*i -: 8];
      s[i]  = pt[127-8*i -: 8];
    end
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        f = t[0];
        t[0] = fmc_pkg::SBOX[t[1]] ^ rc;
        t[1] = fmc_pkg::SBOX[t[2]];
        t[2] = fmc_pkg::SBOX[t[3]];
        t[3] = fmc_pkg::SBOX[f];
        rc = gmul2(rc);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
    end
    for (int i = 0; i < 16; i++) s[i] ^= rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int i = 0; i < 16; i++) s[i] = fmc_pkg::SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int w = 0; w < 4; w++) o[w+4*c] = s[w + 4*((c+w) & 3)];
      s = o;
      if (r < 10) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          x = a0 ^ a1 ^ a2 ^ a3;
          s[4*c]   = a0 ^ x ^ gmul2(a0 ^ a1);
          s[4*c+1] = a1 ^ x ^ gmul2(a1 ^ a2);
          s[4*c+2] = a2 ^ x ^ gmul2(a2 ^ a3);
          s[4*c+3] = a3 ^ x ^ gmul2(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
    end
    for (int i = 0; i < 16; i++) ct[127-8*i -: 8] = s[i];
    return ct;
  endfunction

  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ (v[127] ? 128'h87 : 128'h0);
  endfunction

  // close the message: encrypt last block over chain, MIC = first four cipher bytes
  function automatic void close_msg(input logic [127:0] last);
    logic [127:0] y;
    y = aes128(key_m, last ^ chain_m);
    mic_q.push_back({y[103:96], y[111:104], y[119:112], y[127:120]});
    open_m = 1'b0;
    fill_m = 0;
    left_m = '0;
  endfunction

  function automatic void cmac_step(input beat_t b);
    logic [127:0] hdr, last;
    int n;
    if (b.cmd == fmc_pkg::CMD_START) begin
      hdr = {fmc_pkg::HDR_TAG, 32'h0, 7'h0, dir_m,
             dev_addr_m[7:0], dev_addr_m[15:8], dev_addr_m[23:16], dev_addr_m[31:24],
             b.fcnt[7:0], b.fcnt[15:8], 24'h0, b.mlen};
      k1_m = gf_double(aes128(key_m, 128'h0));
      k2_m = gf_double(k1_m);
      chain_m = '0;
      blk_m = hdr;
      if (b.mlen == 0) begin
        close_msg(hdr ^ k1_m);   // empty message: header is the last full block
      end else begin
        chain_m = aes128(key_m, hdr);
        left_m = b.mlen;
        fill_m = 0;
        open_m = 1'b1;
      end
      return;
    end
    if (!open_m) return;         // stray data byte, dropped
    blk_m[127-8*fill_m -: 8] = b.dbyte;
    n = fill_m + 1;
    left_m = left_m - 8'd1;
    if (left_m == 0) begin
      if (n == 16) begin
        last = blk_m ^ k1_m;
      end else begin
        last = blk_m;
        for (int i = n; i < 16; i++)
          last[127-8*i -: 8] = (i == n) ? fmc_pkg::PAD_BYTE : 8'h00;
        last ^= k2_m;
      end
      close_msg(last);
    end else if (n == 16) begin
      chain_m = aes128(key_m, blk_m ^ chain_m);
      fill_m = 0;
    end else begin
      fill_m = n;
    end
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    err_cnt++;
  endtask

  // beat builders; unused fields are randomized
  function automatic void push_start(input logic [15:0] fc, input logic [7:0] len);
    beat_t b;
    b.cmd = fmc_pkg::CMD_START; b.fcnt = fc; b.mlen = len; b.dbyte = 8'($urandom);
    pending_q.push_back(b);
  endfunction

  function automatic void push_byte(input logic [7:0] d);
    beat_t b;
    b.cmd = fmc_pkg::CMD_DATA; b.fcnt = 16'($urandom); b.mlen = 8'($urandom); b.dbyte = d;
    pending_q.push_back(b);
  endfunction

  // start plus nbytes data beats (nbytes < len leaves the message open)
  function automatic void push_msg(input logic [7:0] len, input int nbytes);
    push_start(16'($urandom), len);
    for (int i = 0; i < nbytes; i++) push_byte(8'($urandom));
  endfunction

  // APB write: setup, then access; model updated once the beat is done
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 3'b000}; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      fmc_pkg::REG_KEY_UPPER: key_m[127:64] = val;
      fmc_pkg::REG_KEY_LOWER: key_m[63:0]   = val;
      fmc_pkg::REG_DEV_ADDR:  dev_addr_m    = val[31:0];
      fmc_pkg::REG_DIRECTION: dir_m         = val[0];
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [63:0] ku, input logic [63:0] kl,
                         input logic [31:0] da, input logic dr);
    cfg_write(fmc_pkg::REG_KEY_UPPER, ku);
    cfg_write(fmc_pkg::REG_KEY_LOWER, kl);
    cfg_write(fmc_pkg::REG_DEV_ADDR, {32'h0, da});
    cfg_write(fmc_pkg::REG_DIRECTION, {63'h0, dr});
  endtask

  // wait until every beat is sent and every MIC is back, then let the engine settle
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || mic_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // random traffic: mostly well-formed messages, some noise and aborted ones
  task automatic random_traffic(input int nbeats);
    int sel, len, base;
    base = pending_q.size();
    while (pending_q.size() - base < nbeats) begin
      sel = $urandom_range(0, 39);
      if (sel < 2) begin
        push_byte(8'($urandom));                       // stray byte
      end else if (sel < 5) begin
        len = $urandom_range(2, 60);
        push_msg(8'(len), $urandom_range(0, len - 1)); // aborted by next start
      end else if (sel == 5) begin
        push_msg(8'd255, 255);
      end else if (sel < 12) begin
        len = 16 * $urandom_range(1, 3);               // exact block multiples
        push_msg(8'(len), len);
      end else begin
        len = $urandom_range(0, 40);
        push_msg(8'(len), len);
      end
    end
  endtask

  // stimulus driver: one beat offered per cycle while beats are taken, random idle bursts
  always @(negedge clk) begin
    beat_t b;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_acc) begin
      // hold until taken
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_tvalid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      in_gap <= $urandom_range(0, 10);
      in_tvalid <= 1'b0;
    end else if (pending_q.size() != 0) begin
      b = pending_q.pop_front();
      in_tdata  <= {b.dbyte, b.mlen, b.fcnt};
      in_tuser  <= b.cmd;
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result sink backpressure
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_gap <= $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor: predict on accepted input beats, check accepted MIC beats, watchdog
  always @(posedge clk) begin
    beat_t b;
    logic [31:0] exp;
    in_acc <= in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        b.cmd = in_tuser; b.fcnt = in_tdata[15:0];
        b.mlen = in_tdata[23:16]; b.dbyte = in_tdata[31:24];
        cmac_step(b);
      end
      if (out_tvalid && out_tready) begin
        if (mic_q.size() == 0) begin
          report("unexpected mic", out_tdata, 32'h0);
        end else begin
          exp = mic_q.pop_front();
          if (out_tdata !== exp) report("mic", out_tdata, exp);
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    key_m = '0; dev_addr_m = '0; dir_m = 1'b0;
    k1_m = '0; k2_m = '0; chain_m = '0; blk_m = '0;
    left_m = '0; fill_m = 0; open_m = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset config then all-zero writes
    cfg_all(64'h0, 64'h0, 32'h0, 1'b0);
    push_byte(8'hff);                 // data with no open message
    push_start(16'h0000, 8'd0);       // empty message
    push_msg(8'd1, 1);
    push_msg(8'd5, 2);                // dropped by the next start
    push_start(16'hffff, 8'd16);      // full last block, k1 path
    for (int i = 0; i < 15; i++) push_byte(8'h00);
    push_byte(8'hff);
    drain();                          // sender holds until all MICs are back

    // extremes: all-ones config, longest message
    cfg_all('1, '1, '1, 1'b1);
    push_start(16'hffff, 8'd0);
    push_start(16'h00ff, 8'd255);
    for (int i = 0; i < 255; i++) push_byte(i[7:0]);
    drain();

    for (int p = 0; p < 4; p++) begin
      cfg_all({$urandom, $urandom}, {$urandom, $urandom}, $urandom,
              1'($urandom_range(0, 1)));
      random_traffic(130);
      if (p == 3) begin
        while (pending_q.size() > 80) @(posedge clk);
        quiet = 1'b1;                 // tail runs at full rate
      end
      drain();
    end

    if (err_cnt == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
